[rtl/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg: shared constants for the pressure compensation block
// Field widths, register indexes and the fixed numbers of the compensation.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned TempW   = 16;
  localparam int unsigned PresW   = 19;
  localparam int unsigned TenthsW = 16;
  localparam int unsigned PascalW = 32;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [WordW-1:0] word_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOss  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAc12 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAc34 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAc56 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgB12  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMcMd = 3'd5;

  // Compensation constants
  localparam word_t B6Offset  = 32'd4000;
  localparam word_t B4Bias    = 32'd32768;
  localparam word_t B7Scale   = 32'd50000;
  localparam word_t B7Limit   = 32'h8000_0000;
  localparam word_t PolyA     = 32'd3038;
  localparam word_t PolyB     = 32'd7357;
  localparam word_t PolyC     = 32'd3791;
  localparam word_t RoundT    = 32'd8;

endpackage

[rtl/bpc_if.sv]
// ----------------------------------------------------------------------------
// bpc_in_if / bpc_out_if: valid/ready channels of the compensation block
// One raw sample pair in, one compensated result out.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  import bpc_pkg::*;
  logic                valid;
  logic                ready;
  logic [TempW-1:0]    raw_temp_word;
  logic [PresW-1:0]    raw_pres_word;

  modport source (output valid, raw_temp_word, raw_pres_word, input ready);
  modport sink   (input valid, raw_temp_word, raw_pres_word, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [TenthsW-1:0]  temp_tenths;
  logic signed [PascalW-1:0]  pres_pascal;
  logic                       divide_fault;

  modport source (output valid, temp_tenths, pres_pascal, divide_fault, input ready);
  modport sink   (input valid, temp_tenths, pres_pascal, divide_fault, output ready);
endinterface

[rtl/bpc_udiv.sv]
// ----------------------------------------------------------------------------
// bpc_udiv: pipelined unsigned restoring divider
// One quotient bit per stage, Width stages, side data travels with each item.
// ----------------------------------------------------------------------------
module bpc_udiv #(
  parameter int unsigned Width = 32,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [Width-1:0] dvd_i,
  input  logic [Width-1:0] dsr_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [Width-1:0] quo_o,
  output logic [SideW-1:0] side_o
);

  logic             vld_q  [Width];
  logic [Width-1:0] rem_q  [Width];
  logic [Width-1:0] dvd_q  [Width];
  logic [Width-1:0] dsr_q  [Width];
  logic [SideW-1:0] side_q [Width];

  for (genvar k = 0; k < Width; k++) begin : g_stage
    logic             vld_in;
    logic [Width-1:0] rem_in, dvd_in, dsr_in;
    logic [SideW-1:0] side_in;
    logic [Width:0]   trial;
    logic [Width-1:0] rem_d, dvd_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign dvd_in  = dvd_i;
      assign dsr_in  = dsr_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dvd_in  = dvd_q[k-1];
      assign dsr_in  = dsr_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in the next dividend bit and try the subtract
    always_comb begin
      trial = {rem_in, dvd_in[Width-1]} - {1'b0, dsr_in};
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        dvd_d = {dvd_in[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_in[Width-2:0], dvd_in[Width-1]};
        dvd_d = {dvd_in[Width-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        dvd_q[k]  <= dvd_d;
        dsr_q[k]  <= dsr_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Width-1];
  assign quo_o   = dvd_q[Width-1];
  assign side_o  = side_q[Width-1];

endmodule

[rtl/barometric_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: temperature and pressure compensation
// Turns raw UT/UP sensor words into 0.1 degC and Pa with stored calibration.
// ----------------------------------------------------------------------------
// One sample pair enters per cycle while the pipeline advances. It passes
// two 32-stage pipelined dividers (temperature divide by X1+MD, pressure
// divide by B4) and 13 arithmetic stages, some with several 32-bit
// multipliers. The whole pipeline advances as one when the output register
// is empty or its transfer completes; in ready is that same advance signal,
// so a stall holds every item in place. A zero divisor raises divide_fault
// and forces both values to zero. The user must write the calibration and
// oversampling registers through the plain write port while the pipeline is
// empty; the block does not enforce it. Indexes beyond the list are dropped.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bpc_pkg::WordW-1:0]   cfg_wdata_i,
  bpc_in_if.sink                   in_i,
  bpc_out_if.source                out_o
);
  import bpc_pkg::*;

  // configuration registers
  logic [1:0] oss_q;
  word_t      ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oss_q  <= '0;
      ac12_q <= '0;
      ac34_q <= '0;
      ac56_q <= '0;
      b12_q  <= '0;
      mcmd_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOss:  oss_q  <= cfg_wdata_i[1:0];
        CfgAc12: ac12_q <= cfg_wdata_i;
        CfgAc34: ac34_q <= cfg_wdata_i;
        CfgAc56: ac56_q <= cfg_wdata_i;
        CfgB12:  b12_q  <= cfg_wdata_i;
        CfgMcMd: mcmd_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // coefficient views, extended to 32 bits
  word_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ac12_q[15]}}, ac12_q[15:0]};
  assign ac2 = {{16{ac12_q[31]}}, ac12_q[31:16]};
  assign ac3 = {{16{ac34_q[15]}}, ac34_q[15:0]};
  assign ac4 = {16'h0, ac34_q[31:16]};
  assign ac5 = {16'h0, ac56_q[15:0]};
  assign ac6 = {16'h0, ac56_q[31:16]};
  assign b1  = {{16{b12_q[15]}}, b12_q[15:0]};
  assign b2  = {{16{b12_q[31]}}, b12_q[31:16]};
  assign mc  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};
  assign md  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};

  // advance the whole pipeline when the output slot frees up
  logic en, out_vld_q;
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // stage 1: (UT - AC6) * AC5
  logic s1_vld_q;
  word_t s1_prod_q;
  logic [PresW-1:0] s1_up_q;

  // stage 2: temperature divide operands as magnitudes
  logic s2_vld_q, s2_neg_q, s2_flt_q;
  word_t s2_x1_q, s2_num_q, s2_den_q;
  logic [PresW-1:0] s2_up_q;
  word_t s2_x1, s2_div, s2_num;
  assign s2_x1  = word_t'($signed(s1_prod_q) >>> 15);
  assign s2_div = s2_x1 + md;
  assign s2_num = mc << 11;

  localparam int unsigned Side1W = WordW + PresW + 2;
  logic d1_vld;
  word_t d1_quo;
  logic [Side1W-1:0] d1_side;
  word_t d1_x1;
  logic [PresW-1:0] d1_up;
  logic d1_neg, d1_flt;
  assign {d1_x1, d1_up, d1_neg, d1_flt} = d1_side;

  // stage 3: B5, temperature result, B6
  logic s3_vld_q, s3_flt_q;
  word_t s3_b6_q;
  logic [TenthsW-1:0] s3_t_q;
  logic [PresW-1:0] s3_up_q;
  word_t s3_b5;
  assign s3_b5 = d1_x1 + (d1_neg ? (32'd0 - d1_quo) : d1_quo);

  // stage 4: B6 squared and coefficient products
  logic s4_vld_q, s4_flt_q;
  word_t s4_sqp_q, s4_ac2b6_q, s4_ac3b6_q;
  logic [TenthsW-1:0] s4_t_q;
  logic [PresW-1:0] s4_up_q;

  // stage 5: products with the scaled square
  logic s5_vld_q, s5_flt_q;
  word_t s5_b2sq_q, s5_b1sq_q, s5_x2a_q, s5_x1c_q;
  logic [TenthsW-1:0] s5_t_q;
  logic [PresW-1:0] s5_up_q;
  word_t s5_sq;
  assign s5_sq = word_t'($signed(s4_sqp_q) >>> 12);

  // stage 6: B3 and the B4 factor
  logic s6_vld_q, s6_flt_q;
  word_t s6_b3_q, s6_b4f_q;
  logic [TenthsW-1:0] s6_t_q;
  logic [PresW-1:0] s6_up_q;
  word_t s6_x3, s6_b3s, s6_x3b;
  always_comb begin
    s6_x3  = word_t'($signed(s5_b2sq_q) >>> 11) + s5_x2a_q;
    s6_b3s = ((ac1 << 2) + s6_x3) << oss_q;
    s6_x3b = s5_x1c_q + word_t'($signed(s5_b1sq_q) >>> 16) + 32'd2;
  end

  // stage 7: B4 product and UP - B3
  logic s7_vld_q, s7_flt_q;
  word_t s7_b4m_q, s7_b7d_q;
  logic [TenthsW-1:0] s7_t_q;

  // stage 8: B4 and B7
  logic s8_vld_q, s8_flt_q;
  word_t s8_b4_q, s8_b7_q;
  logic [TenthsW-1:0] s8_t_q;

  localparam int unsigned Side2W = TenthsW + 2;
  logic d2_big;
  word_t d2_dvd;
  assign d2_big = !(s8_b7_q < B7Limit);
  assign d2_dvd = d2_big ? s8_b7_q : (s8_b7_q << 1);

  logic d2_vld;
  word_t d2_quo;
  logic [Side2W-1:0] d2_side;
  logic [TenthsW-1:0] d2_t;
  logic d2_post, d2_flt;
  assign {d2_t, d2_post, d2_flt} = d2_side;

  // stage 9: raw pressure p
  logic s9_vld_q, s9_flt_q;
  word_t s9_p_q;
  logic [TenthsW-1:0] s9_t_q;

  // stage 10: (p>>8)^2 and 7357*p
  logic s10_vld_q, s10_flt_q;
  word_t s10_p_q, s10_sqm_q, s10_m2_q;
  logic [TenthsW-1:0] s10_t_q;
  word_t s10_ps;
  assign s10_ps = word_t'($signed(s9_p_q) >>> 8);

  // stage 11: scale by 3038, shift the 7357 term
  logic s11_vld_q, s11_flt_q;
  word_t s11_p_q, s11_a_q, s11_x2_q;
  logic [TenthsW-1:0] s11_t_q;

  // stage 12: correction sum
  logic s12_vld_q, s12_flt_q;
  word_t s12_p_q, s12_s_q;
  logic [TenthsW-1:0] s12_t_q;

  // output: divide the sum by 16 toward zero, add to p
  word_t out_adj, out_pres;
  assign out_adj  = s12_s_q[31] ? word_t'($signed(s12_s_q + 32'd15) >>> 4)
                                : word_t'($signed(s12_s_q) >>> 4);
  assign out_pres = s12_p_q + out_adj;

  logic [TenthsW-1:0] out_t_q;
  word_t              out_p_q;
  logic               out_flt_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      s12_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_i.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= d1_vld;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= d2_vld;
      s10_vld_q <= s9_vld_q;
      s11_vld_q <= s10_vld_q;
      s12_vld_q <= s11_vld_q;
      out_vld_q <= s12_vld_q;
    end
  end

  // payload path
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= ({16'h0, in_i.raw_temp_word} - ac6) * ac5;
      s1_up_q   <= in_i.raw_pres_word;

      s2_x1_q  <= s2_x1;
      s2_up_q  <= s1_up_q;
      s2_neg_q <= s2_num[31] ^ s2_div[31];
      s2_flt_q <= (s2_div == '0);
      s2_num_q <= s2_num[31] ? (32'd0 - s2_num) : s2_num;
      s2_den_q <= s2_div[31] ? (32'd0 - s2_div) : s2_div;

      s3_flt_q <= d1_flt;
      s3_up_q  <= d1_up;
      s3_b6_q  <= s3_b5 - B6Offset;
      s3_t_q   <= TenthsW'($signed(s3_b5 + RoundT) >>> 4);

      s4_flt_q   <= s3_flt_q;
      s4_up_q    <= s3_up_q;
      s4_t_q     <= s3_t_q;
      s4_sqp_q   <= s3_b6_q * s3_b6_q;
      s4_ac2b6_q <= ac2 * s3_b6_q;
      s4_ac3b6_q <= ac3 * s3_b6_q;

      s5_flt_q  <= s4_flt_q;
      s5_up_q   <= s4_up_q;
      s5_t_q    <= s4_t_q;
      s5_b2sq_q <= b2 * s5_sq;
      s5_b1sq_q <= b1 * s5_sq;
      s5_x2a_q  <= word_t'($signed(s4_ac2b6_q) >>> 11);
      s5_x1c_q  <= word_t'($signed(s4_ac3b6_q) >>> 13);

      s6_flt_q <= s5_flt_q;
      s6_up_q  <= s5_up_q;
      s6_t_q   <= s5_t_q;
      s6_b3_q  <= word_t'($signed(s6_b3s + 32'd2) >>> 2);
      s6_b4f_q <= word_t'($signed(s6_x3b) >>> 2) + B4Bias;

      s7_flt_q <= s6_flt_q;
      s7_t_q   <= s6_t_q;
      s7_b4m_q <= ac4 * s6_b4f_q;
      s7_b7d_q <= {13'h0, s6_up_q} - s6_b3_q;

      s8_flt_q <= s7_flt_q;
      s8_t_q   <= s7_t_q;
      s8_b4_q  <= s7_b4m_q >> 15;
      s8_b7_q  <= s7_b7d_q * (B7Scale >> oss_q);

      s9_flt_q <= d2_flt;
      s9_t_q   <= d2_t;
      s9_p_q   <= d2_post ? (d2_quo << 1) : d2_quo;

      s10_flt_q <= s9_flt_q;
      s10_t_q   <= s9_t_q;
      s10_p_q   <= s9_p_q;
      s10_sqm_q <= s10_ps * s10_ps;
      s10_m2_q  <= PolyB * s9_p_q;

      s11_flt_q <= s10_flt_q;
      s11_t_q   <= s10_t_q;
      s11_p_q   <= s10_p_q;
      s11_a_q   <= s10_sqm_q * PolyA;
      s11_x2_q  <= word_t'($signed(32'd0 - s10_m2_q) >>> 16);

      s12_flt_q <= s11_flt_q;
      s12_t_q   <= s11_t_q;
      s12_p_q   <= s11_p_q;
      s12_s_q   <= word_t'($signed(s11_a_q) >>> 16) + s11_x2_q + PolyC;

      // drop both values on a zero divisor
      out_flt_q <= s12_flt_q;
      out_t_q   <= s12_flt_q ? '0 : s12_t_q;
      out_p_q   <= s12_flt_q ? '0 : out_pres;
    end
  end

  bpc_udiv #(
    .Width (WordW),
    .SideW (Side1W)
  ) u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .dvd_i   (s2_num_q),
    .dsr_i   (s2_den_q),
    .side_i  ({s2_x1_q, s2_up_q, s2_neg_q, s2_flt_q}),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_side)
  );

  bpc_udiv #(
    .Width (WordW),
    .SideW (Side2W)
  ) u_pdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_vld_q),
    .dvd_i   (d2_dvd),
    .dsr_i   (s8_b4_q),
    .side_i  ({s8_t_q, d2_big, s8_flt_q || (s8_b4_q == '0)}),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_side)
  );

  assign out_o.valid        = out_vld_q;
  assign out_o.temp_tenths  = $signed(out_t_q);
  assign out_o.pres_pascal  = $signed(out_p_q);
  assign out_o.divide_fault = out_flt_q;

endmodule

[rtl/bpc_checker.sv]
// ----------------------------------------------------------------------------
// bpc_checker: port-level checks for the compensation block
// Watches the two channels and the fault rule; bound to the top level.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] temp_tenths_i,
  input logic [31:0] pres_pascal_i,
  input logic        divide_fault_i
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pres_pascal_i)
      && $stable(temp_tenths_i) && $stable(divide_fault_i))
    else $error("result changed while stalled");

  // a fault result carries zero values
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && divide_fault_i |-> temp_tenths_i == '0 && pres_pascal_i == '0)
    else $error("fault result not zero");

  // a stalled output stalls the input
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken during output stall");

  // an empty output slot never blocks the input
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .temp_tenths_i  (out_o.temp_tenths),
  .pres_pascal_i  (out_o.pres_pascal),
  .divide_fault_i (out_o.divide_fault)
);

[tb/tb_barometric_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// tb_barometric_pressure_compensation: self-checking bench for the block
// Drives raw sample pairs through random idle and stall patterns, predicts
// each compensated result in software and compares it field by field.
// ----------------------------------------------------------------------------
module tb_barometric_pressure_compensation;
  import bpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TempW-1:0] ut;
    logic [PresW-1:0] up;
  } sample_t;

  typedef struct packed {
    logic signed [TenthsW-1:0] tenths;
    logic signed [PascalW-1:0] pascal;
    logic                      fault;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [WordW-1:0] cfg_wdata_i = '0;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  barometric_pressure_compensation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Shadow copy of the calibration registers
  logic [1:0]  oss_q;
  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       error_count = 0;
  bit       quiet_phase = 1'b0;
  bit       drive_enable = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  // Signed divide truncating toward zero, done in 64 bits so that the
  // most negative dividend over -1 wraps like the hardware does
  function automatic logic [31:0] sdiv32(input logic [31:0] a, input logic [31:0] b);
    longint qa, qb;
    qa = longint'($signed(a));
    qb = longint'($signed(b));
    return 32'(qa / qb);
  endfunction

  function automatic reading_t compensate(input sample_t s);
    reading_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, dv, p, t;
    ac1 = sx16(ac12_q[15:0]);  ac2 = sx16(ac12_q[31:16]);
    ac3 = sx16(ac34_q[15:0]);  ac4 = {16'd0, ac34_q[31:16]};
    ac5 = {16'd0, ac56_q[15:0]}; ac6 = {16'd0, ac56_q[31:16]};
    b1 = sx16(b12_q[15:0]);    b2 = sx16(b12_q[31:16]);
    mc = sx16(mcmd_q[15:0]);   md = sx16(mcmd_q[31:16]);
    r = '{tenths: '0, pascal: '0, fault: 1'b1};

    x1 = sra(({16'd0, s.ut} - ac6) * ac5, 15);
    dv = x1 + md;
    if (dv == 0) return r;
    x2 = sdiv32(mc * 32'd2048, dv);
    b5 = x1 + x2;
    t  = sra(b5 + 32'd8, 4);

    b6 = b5 - B6Offset;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra(((ac1 * 32'd4 + x3) << oss_q) + 32'd2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + B4Bias)) >> 15;
    if (b4 == 0) return r;
    b7 = ({13'd0, s.up} - b3) * (B7Scale >> oss_q);

    // Datasheet branch: scale before the divide while B7 still fits
    if (b7 < B7Limit) p = (b7 * 32'd2) / b4;
    else              p = (b7 / b4) * 32'd2;

    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * PolyA, 16);
    x2 = sra(32'd0 - PolyB * p, 16);
    p  = p + sdiv32(x1 + x2 + PolyC, 32'd16);

    r.tenths = t[15:0];
    r.pascal = p;
    r.fault  = 1'b0;
    return r;
  endfunction

  // Driver: advance to the next sample only after a transfer
  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      expected_readings.push_back(compensate({in_ch.raw_temp_word, in_ch.raw_pres_word}));
    end
    if (!in_ch.valid || in_ch.ready) begin
      if (drive_enable && pending_samples.size() > 0 &&
          (quiet_phase || $urandom_range(99) >= 18)) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.raw_temp_word <= s.ut;
        in_ch.raw_pres_word <= s.up;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: stall the output at random, check every transfer
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: tenths %0d pascal %0d", out_ch.temp_tenths,
               out_ch.pres_pascal);
        error_count++;
      end else begin
        reading_t e;
        e = expected_readings.pop_front();
        if (out_ch.temp_tenths !== e.tenths) begin
          $error("temp_tenths: expected %0d, actual %0d", e.tenths, out_ch.temp_tenths);
          error_count++;
        end
        if (out_ch.pres_pascal !== e.pascal) begin
          $error("pres_pascal: expected %0d, actual %0d", e.pascal, out_ch.pres_pascal);
          error_count++;
        end
        if (out_ch.divide_fault !== e.fault) begin
          $error("divide_fault: expected %0b, actual %0b", e.fault, out_ch.divide_fault);
          error_count++;
        end
      end
    end
    out_ch.ready <= quiet_phase || ($urandom_range(99) >= 18);
  end

  // Drive the write with its enable, then drop the enable and keep the port idle before the next write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CfgOss:  oss_q  = val[1:0];
      CfgAc12: ac12_q = val;
      CfgAc34: ac34_q = val;
      CfgAc56: ac56_q = val;
      CfgB12:  b12_q  = val;
      CfgMcMd: mcmd_q = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Drain the pipeline so the registers can change safely
  task automatic drain();
    drive_enable = 1'b1;
    wait (pending_samples.size() == 0 && !in_ch.valid && expected_readings.size() == 0);
    repeat (90) @(posedge clk_i);
    drive_enable = 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_calibration(input logic [1:0] oss, input logic [31:0] a12,
                                  input logic [31:0] a34, input logic [31:0] a56,
                                  input logic [31:0] bb, input logic [31:0] mm);
    write_reg(CfgOss, {30'd0, oss});
    write_reg(CfgAc12, a12);
    write_reg(CfgAc34, a34);
    write_reg(CfgAc56, a56);
    write_reg(CfgB12, bb);
    write_reg(CfgMcMd, mm);
  endtask

  function automatic sample_t rand_sample(input logic [1:0] oss);
    sample_t s;
    s.ut = 16'($urandom);
    // Mostly pressure words below 16 bits shifted by oss, sometimes the full 19-bit range
    if ($urandom_range(3) == 0) s.up = 19'($urandom);
    else s.up = 19'($urandom_range((32'h10000 << oss) - 1));
    return s;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_temp_word = '0;
    in_ch.raw_pres_word = '0;
    out_ch.ready = 1'b0;
    oss_q = '0; ac12_q = '0; ac34_q = '0; ac56_q = '0; b12_q = '0; mcmd_q = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: X1 and MD are zero so every sample faults on the
    // temperature divide
    pending_samples.push_back('{16'd27898, 19'd23843});
    drain();

    // Datasheet calibration, directed extremes
    load_calibration(2'd0, {16'hFFB8, 16'd408}, {16'd32741, 16'hC5C3},
                     {16'd23153, 16'd32757}, {16'd4, 16'd6190},
                     {16'd2868, 16'hD4BD});
    pending_samples.push_back('{16'd27898, 19'd23843});
    pending_samples.push_back('{16'd0, 19'd0});
    pending_samples.push_back('{16'hFFFF, 19'h7FFFF});
    pending_samples.push_back('{16'hFFFF, 19'd0});
    pending_samples.push_back('{16'd0, 19'h7FFFF});
    pending_samples.push_back('{16'h5555, 19'h2AAAA});
    pending_samples.push_back('{16'hAAAA, 19'h55555});
    drain();

    // Zero temperature divisor: X1 = 0 with MD = 0
    load_calibration(2'd3, 32'h7FFF_8000, 32'hFFFF_8000, 32'h0000_0000,
                     32'h8000_7FFF, 32'h0000_1234);
    pending_samples.push_back('{16'd1000, 19'd5000});
    drain();

    // Zero pressure divisor: AC4 = 0, with a large UP
    load_calibration(2'd1, {16'd100, 16'd200}, {16'd0, 16'd10}, {16'd100, 16'd200},
                     {16'd5, 16'd5}, {16'd10, 16'd100});
    pending_samples.push_back('{16'd300, 19'd70000});
    write_reg(CfgMcMd, {16'd10, 16'd100});
    drain();

    // Random phases through several calibrations, quiet stretch in the middle
    for (int ph = 0; ph < 8; ph++) begin
      logic [1:0] oss;
      oss = (ph < 4) ? 2'(ph) : 2'($urandom);
      if (ph % 2 == 0)
        load_calibration(oss, {16'd408 + 16'($urandom_range(200)), 16'hFFB8},
                         {16'd32741 - 16'($urandom_range(2000)), 16'hC5C3},
                         {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                         {16'hD4BD, 16'd2868});
      else
        load_calibration(oss, $urandom, $urandom, $urandom, $urandom,
                         (ph == 7) ? 32'hFFFF_FFFF : $urandom);
      write_reg(3'd7, $urandom);
      quiet_phase = (ph == 5);
      for (int i = 0; i < 105; i++) pending_samples.push_back(rand_sample(oss_q));
      drain();
    end
    quiet_phase = 1'b0;

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
